/* rtl/assert_macros.svh */
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

/* rtl/fdt_pkg.sv */
// Types, constants and helpers shared by the decimal formatter modules.
`timescale 1ns / 1ps

package fdt_pkg;

    // Default parameter values.
    localparam int INT_DIGITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 32;

    // Character codes and precision limits.
    localparam logic [7:0] ASCII_ZERO      = 8'd48;
    localparam logic [7:0] ASCII_DOT       = 8'd46;
    localparam logic [3:0] DEFAULT_DIGITS  = 4'd6;
    localparam logic [3:0] MAX_FRAC_DIGITS = 4'd9;

    // Reciprocal of ten: floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x.
    localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // Input item.
    typedef struct packed {
        logic [30:0] integer_part;
        logic [31:0] fraction_part;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_out_item;

    // Width of a count that holds 0..n.
    function automatic int count_width(input int n);
        return $clog2(n + 1);
    endfunction

    // Width of an index over n entries, never below one bit.
    function automatic int index_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Width of one job record passed from front to back.
    function automatic int job_width(input int int_digits, input int frac_bits);
        return int_digits * 4 + count_width(int_digits) + frac_bits + 4;
    endfunction

endpackage

/* rtl/fdt_front.sv */
// Front end: takes a value, splits the whole part into decimal digits, queues a job.
`timescale 1ns / 1ps

module fdt_front
    import fdt_pkg::*;
#(
    parameter int INT_DIGITS = INT_DIGITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  t_in_item                               i_item,
    input  logic                                   i_cfg_we,
    input  logic [3:0]                             i_cfg_data,
    output logic                                   o_job_valid,
    input  logic                                   i_job_stall,
    output logic [job_width(INT_DIGITS, FRAC_BITS)-1:0] o_job
);

    localparam int NDIG_W = count_width(INT_DIGITS);
    localparam int IDX_W  = index_width(INT_DIGITS);

    typedef struct packed {
        logic [INT_DIGITS-1:0][3:0] digs;
        logic [NDIG_W-1:0]          ndig;
        logic [FRAC_BITS-1:0]       frac;
        logic [3:0]                 fdig;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [3:0]                 r_cfg;
    logic [30:0]                r_x;
    logic [IDX_W-1:0]           r_k;
    logic [INT_DIGITS-1:0][3:0] r_digs;
    logic [NDIG_W-1:0]          r_ndig;
    logic [FRAC_BITS-1:0]       r_frac;
    logic [3:0]                 r_fdig;

    logic [FRAC_BITS-1:0] w_frac;
    logic [3:0]           w_fdig;
    logic [63:0]          w_prod;
    logic [30:0]          w_q;
    logic [30:0]          w_q10;
    logic [3:0]           w_rem;
    logic                 w_accept;
    logic                 w_conv_done;
    t_job                 w_job;

    // Align the Q0.32 input to the working fraction width.
    if (FRAC_BITS >= 32) begin : g_frac_up
        assign w_frac = FRAC_BITS'(i_item.fraction_part) << (FRAC_BITS - 32);
    end else begin : g_frac_down
        assign w_frac = FRAC_BITS'(i_item.fraction_part >> (32 - FRAC_BITS));
    end

    // Precision: zero selects the default, anything above nine saturates.
    always_comb begin
        priority if (r_cfg == 4'd0) begin
            w_fdig = DEFAULT_DIGITS;
        end else if (r_cfg > MAX_FRAC_DIGITS) begin
            w_fdig = MAX_FRAC_DIGITS;
        end else begin
            w_fdig = r_cfg;
        end
    end

    // One decimal digit per cycle: quotient by reciprocal multiply, remainder by subtract.
    always_comb begin
        w_prod      = {33'd0, r_x} * {32'd0, RECIP_10};
        w_q         = 31'(w_prod >> RECIP_SHIFT);
        w_q10       = {w_q[27:0], 3'b000} + {w_q[29:0], 1'b0};
        w_rem       = 4'(r_x - w_q10);
        w_conv_done = (r_k == IDX_W'(INT_DIGITS - 1)) || (w_q == 31'd0);
    end

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_CONV;
            end
            S_CONV: begin
                if (w_conv_done) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!i_job_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and the precision register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cfg   <= 4'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_cfg <= i_cfg_data;
        end
    end

    // Working registers of the current value.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_item.integer_part;
            r_frac <= w_frac;
            r_fdig <= w_fdig;
            r_k    <= '0;
            r_ndig <= NDIG_W'(1);
        end else if (r_state == S_CONV) begin
            r_digs[r_k] <= w_rem;
            if (w_rem != 4'd0) r_ndig <= NDIG_W'(r_k) + NDIG_W'(1);
            r_x <= w_q;
            r_k <= r_k + IDX_W'(1);
        end
    end

    // Job record towards the queue.
    always_comb begin
        w_job.digs = r_digs;
        w_job.ndig = r_ndig;
        w_job.frac = r_frac;
        w_job.fdig = r_fdig;
    end

    assign o_job_valid = (r_state == S_PUSH);
    assign o_job       = w_job;

endmodule

/* rtl/fdt_queue.sv */
// Two-entry queue that decouples conversion from character output.
`timescale 1ns / 1ps

module fdt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

endmodule

/* rtl/fdt_back.sv */
// Back end: unless stalled, emits one job character per cycle via an output register.
`timescale 1ns / 1ps

module fdt_back
    import fdt_pkg::*;
#(
    parameter int INT_DIGITS = INT_DIGITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_job_valid,
    output logic                                   o_job_stall,
    input  logic [job_width(INT_DIGITS, FRAC_BITS)-1:0] i_job,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output t_out_item                              o_item
);

    localparam int NDIG_W = count_width(INT_DIGITS);
    localparam int IDX_W  = index_width(INT_DIGITS);

    typedef struct packed {
        logic [INT_DIGITS-1:0][3:0] digs;
        logic [NDIG_W-1:0]          ndig;
        logic [FRAC_BITS-1:0]       frac;
        logic [3:0]                 fdig;
    } t_job;

    typedef enum logic [3:0] {
        P_IDLE = 4'b0001,
        P_INT  = 4'b0010,
        P_DOT  = 4'b0100,
        P_FRAC = 4'b1000
    } t_phase;

    t_phase                     r_phase, n_phase;
    logic [INT_DIGITS-1:0][3:0] r_digs;
    logic [IDX_W-1:0]           r_idx;
    logic [FRAC_BITS-1:0]       r_frac;
    logic [3:0]                 r_fcnt;
    logic                       r_oval;
    t_out_item                  r_out;

    t_job                 w_job;
    logic [FRAC_BITS+3:0] w_prod;
    logic                 w_advance;
    logic                 w_load;
    logic                 w_emit;
    t_out_item            w_char;

    assign w_job       = i_job;
    assign o_job_stall = (r_phase != P_IDLE);
    assign w_load      = i_job_valid && !o_job_stall;
    assign w_advance   = !r_oval || !i_stall;

    // Ten times the remaining fraction; the top nibble is the next digit.
    assign w_prod = ({4'd0, r_frac} << 3) + ({4'd0, r_frac} << 1);

    // Character for the current phase and the phase after it.
    always_comb begin
        n_phase = r_phase;
        w_emit  = 1'b0;
        w_char  = '{char_code: ASCII_DOT, last_char: 1'b0};
        unique case (r_phase)
            P_IDLE: begin
                if (w_load) n_phase = P_INT;
            end
            P_INT: begin
                w_emit           = 1'b1;
                w_char.char_code = ASCII_ZERO + {4'd0, r_digs[r_idx]};
                if (w_advance && r_idx == '0) n_phase = P_DOT;
            end
            P_DOT: begin
                w_emit = 1'b1;
                if (w_advance) n_phase = P_FRAC;
            end
            P_FRAC: begin
                w_emit           = 1'b1;
                w_char.char_code = ASCII_ZERO + {4'd0, w_prod[FRAC_BITS+3:FRAC_BITS]};
                w_char.last_char = (r_fcnt == 4'd1);
                if (w_advance && r_fcnt == 4'd1) n_phase = P_IDLE;
            end
            default: n_phase = P_IDLE;
        endcase
    end

    // Phase and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (w_advance) r_oval <= w_emit;
        end
    end

    // Job working registers and the output register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_digs <= w_job.digs;
            r_idx  <= IDX_W'(w_job.ndig - NDIG_W'(1));
            r_frac <= w_job.frac;
            r_fcnt <= w_job.fdig;
        end else if (w_advance) begin
            if (r_phase == P_INT && r_idx != '0) r_idx <= r_idx - IDX_W'(1);
            if (r_phase == P_FRAC) begin
                r_frac <= w_prod[FRAC_BITS-1:0];
                r_fcnt <= r_fcnt - 4'd1;
            end
        end
        if (w_advance && w_emit) r_out <= w_char;
    end

    assign o_valid = r_oval;
    assign o_item  = r_out;

endmodule

/* rtl/fixed_to_decimal_ascii.sv */
// Top level of the fixed-point to decimal ASCII formatter.
// Each accepted value (31-bit whole part, Q0.32 fraction) comes out as a run of ASCII
// transfers: the whole part's decimal digits without leading zeros (at least "0", only the
// low INT_DIGITS digits kept), a period, then fraction_digits truncated fraction digits
// (0 selects six, above nine gives nine); last_char marks the final one. The front end
// produces the whole digits, at most min(INT_DIGITS, 10), one digit per cycle through a
// 31x32 reciprocal multiply. The back end sends one character per cycle while the output
// is not stalled, through the times-ten step on the fraction. A two-entry job queue lets
// the next value convert while the current one is being sent. fraction_digits is sampled
// when a value is accepted and should be written only while the block is idle.
`timescale 1ns / 1ps

module fixed_to_decimal_ascii
    import fdt_pkg::*;
#(
    parameter int INT_DIGITS = INT_DIGITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_item,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    localparam int JOB_W = job_width(INT_DIGITS, FRAC_BITS);

    logic             w_fq_valid;
    logic             w_fq_stall;
    logic [JOB_W-1:0] w_fq_job;
    logic             w_qb_valid;
    logic             w_qb_stall;
    logic [JOB_W-1:0] w_qb_job;

    // Conversion of the whole part.
    fdt_front #(
        .INT_DIGITS(INT_DIGITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_job_valid(w_fq_valid),
        .i_job_stall(w_fq_stall),
        .o_job      (w_fq_job)
    );

    // Job queue.
    fdt_queue #(
        .WIDTH(JOB_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_fq_valid),
        .o_stall(w_fq_stall),
        .i_data (w_fq_job),
        .o_valid(w_qb_valid),
        .i_stall(w_qb_stall),
        .o_data (w_qb_job)
    );

    // Character output.
    fdt_back #(
        .INT_DIGITS(INT_DIGITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(w_qb_valid),
        .o_job_stall(w_qb_stall),
        .i_job      (w_qb_job),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

endmodule

/* rtl/fdt_checker.sv */
// Port-level checks on the formatter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fdt_checker
    import fdt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_stall,
    input t_out_item o_item
);

    logic w_is_dot;
    logic w_is_digit;

    // Classify the character currently on the output.
    assign w_is_dot   = (o_item.char_code == ASCII_DOT);
    assign w_is_digit = (o_item.char_code >= ASCII_ZERO)
                     && (o_item.char_code <= ASCII_ZERO + 8'd9);

    // A stalled result transfer holds its character.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_item))

    // Every character is a digit or the period.
    `ASSERT_IMPLY(a_char_set, i_clk, i_rst_n, o_valid, w_is_dot || w_is_digit)

    // At least one fraction digit always follows the period.
    `ASSERT_IMPLY(a_dot_not_last, i_clk, i_rst_n, o_valid && w_is_dot, !o_item.last_char)

    // Reset leaves no result pending.
    `ASSERT_NEXT(a_reset_idle, i_clk, 1'b1, !i_rst_n, !o_valid)

endmodule

bind fixed_to_decimal_ascii fdt_checker u_fdt_checker (.*);
